[src/oale_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package oale_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int DATA_WIDTH_DEF = 32;

  // word field widths, fixed by the stream format
  localparam int POSITION_W = 7;
  localparam int READ_W     = 32;
  localparam int FIDX_W     = 6;
  localparam int COUNT_W    = 7;
  localparam int S_TDATA_W  = 48;
  localparam int M_TDATA_W  = 48;

  typedef enum logic [3:0] {
    ACT_APPEND     = 4'd0,
    ACT_REMOVE_END = 4'd1,
    ACT_INSERT     = 4'd2,
    ACT_ERASE      = 4'd3,
    ACT_REMOVE_VAL = 4'd4,
    ACT_FIND       = 4'd5,
    ACT_READ       = 4'd6,
    ACT_REVERSE    = 4'd7,
    ACT_CLEAR      = 4'd8
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BADPOS   = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD     = 3'd0,
    CELL_INS      = 3'd1,
    CELL_DEL      = 3'd2,
    CELL_SCAN_POS = 3'd3,
    CELL_SCAN_VAL = 3'd4
  } cell_op_t;

  // broadcast to every cell; rev sets the direction the match chain runs
  typedef struct packed {
    cell_op_t op;
    logic     rev;
  } cell_cmd_t;

endpackage

`default_nettype wire

[src/oale_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module oale_cell #(
  parameter int CAPACITY   = oale_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = oale_pkg::DATA_WIDTH_DEF,
  parameter int INDEX      = 0,
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  wire logic                  clk,
  input  wire oale_pkg::cell_cmd_t   cmd,
  input  wire logic [IW-1:0]         sel_index,
  input  wire logic [DATA_WIDTH-1:0] key,
  input  wire logic [CW-1:0]         count,
  input  wire logic [DATA_WIDTH-1:0] lower_data,
  input  wire logic [DATA_WIDTH-1:0] upper_data,
  output logic      [DATA_WIDTH-1:0] data,
  input  wire logic                  lower_hit,
  input  wire logic [IW-1:0]         lower_idx,
  input  wire logic [DATA_WIDTH-1:0] lower_val,
  input  wire logic                  upper_hit,
  input  wire logic [IW-1:0]         upper_idx,
  input  wire logic [DATA_WIDTH-1:0] upper_val,
  output logic                       hit,
  output logic      [IW-1:0]         idx,
  output logic      [DATA_WIDTH-1:0] hit_val
);
  import oale_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(INDEX);
  localparam logic [CW-1:0] MY_POS = CW'(INDEX);

  logic pick;
  logic scanning;

  always_comb begin
    pick     = 1'b0;
    scanning = 1'b0;
    unique case (cmd.op)
      CELL_SCAN_POS: begin
        scanning = 1'b1;
        pick     = (sel_index == MY_IDX);
      end
      CELL_SCAN_VAL: begin
        scanning = 1'b1;
        pick     = (MY_POS < count) && (data == key);
      end
      default: begin
        scanning = 1'b0;
      end
    endcase
  end

  // entry: shift up for insert, shift down for delete
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      CELL_INS: begin
        if (MY_IDX > sel_index) begin
          data <= lower_data;
        end else if (MY_IDX == sel_index) begin
          data <= key;
        end
      end
      CELL_DEL: begin
        if (MY_IDX >= sel_index) begin
          data <= upper_data;
        end
      end
      default: begin
        data <= data;
      end
    endcase
  end

  // match chain: a picked cell overrides whatever is passing through,
  // so the cell nearest the head wins
  always_ff @(posedge clk) begin
    if (scanning) begin
      if (pick) begin
        hit     <= 1'b1;
        idx     <= MY_IDX;
        hit_val <= data;
      end else if (cmd.rev) begin
        hit     <= lower_hit;
        idx     <= lower_idx;
        hit_val <= lower_val;
      end else begin
        hit     <= upper_hit;
        idx     <= upper_idx;
        hit_val <= upper_val;
      end
    end
  end

endmodule

`default_nettype wire

[src/ordered_array_list_engine.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Fields (tdata, lowest bit first)
// s_*      in   action[3:0] position[10:4] value[42:11], zero pad to 48
// m_*      out  status[1:0] read_value[33:2] found_index[39:34]
//               entry_count[46:40] is_empty[47]
//
// Append, remove last, insert, erase, reverse, clear go from idle straight to commit.
// Read, find, remove value first pass through the scan state, in which the match
// chain through the cells brings the hit to its head, and then commit.
// rst (synchronous) empties the list; stored entries are not cleared.
// A new word is taken while the previous result still waits on m_tready;
// it then stalls before commit until the output register is free.

module ordered_array_list_engine #(
  parameter int CAPACITY   = oale_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = oale_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // action, position, value
  input  wire logic [oale_pkg::S_TDATA_W-1:0]   s_tdata,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // status, read_value, found_index, entry_count, is_empty
  output logic      [oale_pkg::M_TDATA_W-1:0]   m_tdata
);
  import oale_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POSITION_W) ? CW : POSITION_W;
  localparam logic [IW-1:0] SCAN_LAST = IW'(CAPACITY - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  state_t                  state;
  logic [3:0]              act;
  logic [POSITION_W-1:0]   pos;
  logic [DATA_WIDTH-1:0]   key;
  logic [CW-1:0]           count;
  logic                    rev;
  logic [IW-1:0]           scan_cnt;

  logic [DATA_WIDTH-1:0]   ext_data [0:CAPACITY+1];
  logic                    ext_hit  [0:CAPACITY+1];
  logic [IW-1:0]           ext_idx  [0:CAPACITY+1];
  logic [DATA_WIDTH-1:0]   ext_val  [0:CAPACITY+1];

  cell_cmd_t               cmd;
  logic [IW-1:0]           sel_index;

  logic                    out_free;
  logic                    needs_scan;
  logic                    full;
  logic [PW-1:0]           p;
  logic [PW-1:0]           cnt;
  logic                    head_hit;
  logic [IW-1:0]           head_idx;
  logic [DATA_WIDTH-1:0]   head_val;
  logic [PW-1:0]           found_pos;
  logic [PW-1:0]           exec_q;
  logic [PW-1:0]           scan_q;
  cell_op_t                exec_op;
  status_t                 status;
  logic [READ_W-1:0]       rd;
  logic [FIDX_W-1:0]       fidx;
  logic [CW-1:0]           count_next;
  logic                    rev_next;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign needs_scan = (s_tdata[3:0] == ACT_READ) || (s_tdata[3:0] == ACT_FIND) ||
                      (s_tdata[3:0] == ACT_REMOVE_VAL);

  assign ext_data[0]          = '0;
  assign ext_data[CAPACITY+1] = '0;
  assign ext_hit[0]           = 1'b0;
  assign ext_hit[CAPACITY+1]  = 1'b0;
  assign ext_idx[0]           = '0;
  assign ext_idx[CAPACITY+1]  = '0;
  assign ext_val[0]           = '0;
  assign ext_val[CAPACITY+1]  = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    oale_cell #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH),
      .INDEX      (i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .sel_index  (sel_index),
      .key        (key),
      .count      (count),
      .lower_data (ext_data[i]),
      .upper_data (ext_data[i+2]),
      .data       (ext_data[i+1]),
      .lower_hit  (ext_hit[i]),
      .lower_idx  (ext_idx[i]),
      .lower_val  (ext_val[i]),
      .upper_hit  (ext_hit[i+2]),
      .upper_idx  (ext_idx[i+2]),
      .upper_val  (ext_val[i+2]),
      .hit        (ext_hit[i+1]),
      .idx        (ext_idx[i+1]),
      .hit_val    (ext_val[i+1])
    );
  end

  // list is held in reverse physical order while rev is set
  always_comb begin
    p        = PW'(pos);
    cnt      = PW'(count);
    full     = (count == CW'(CAPACITY));
    head_hit = rev ? ext_hit[CAPACITY] : ext_hit[1];
    head_idx = rev ? ext_idx[CAPACITY] : ext_idx[1];
    head_val = rev ? ext_val[CAPACITY] : ext_val[1];
    found_pos = rev ? (cnt - PW'(1) - PW'(head_idx)) : PW'(head_idx);
    scan_q   = rev ? (cnt - PW'(1) - p) : p;

    exec_op    = CELL_HOLD;
    exec_q     = '0;
    status     = ST_OK;
    rd         = '0;
    fidx       = '0;
    count_next = count;
    rev_next   = rev;

    unique case (act)
      ACT_APPEND: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          exec_op    = CELL_INS;
          exec_q     = rev ? '0 : cnt;
          count_next = count + CW'(1);
        end
      end
      ACT_REMOVE_END: begin
        if (count == '0) begin
          status = ST_BADPOS;
        end else begin
          exec_op    = CELL_DEL;
          exec_q     = rev ? '0 : (cnt - PW'(1));
          count_next = count - CW'(1);
        end
      end
      ACT_INSERT: begin
        if (p > cnt) begin
          status = ST_BADPOS;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          exec_op    = CELL_INS;
          exec_q     = rev ? (cnt - p) : p;
          count_next = count + CW'(1);
        end
      end
      ACT_ERASE: begin
        if (p >= cnt) begin
          status = ST_BADPOS;
        end else begin
          exec_op    = CELL_DEL;
          exec_q     = scan_q;
          count_next = count - CW'(1);
        end
      end
      ACT_REMOVE_VAL: begin
        if (head_hit) begin
          exec_op    = CELL_DEL;
          exec_q     = PW'(head_idx);
          fidx       = FIDX_W'(found_pos);
          count_next = count - CW'(1);
        end else begin
          status = ST_NOTFOUND;
        end
      end
      ACT_FIND: begin
        if (head_hit) begin
          fidx = FIDX_W'(found_pos);
        end else begin
          status = ST_NOTFOUND;
        end
      end
      ACT_READ: begin
        if (p >= cnt) begin
          status = ST_BADPOS;
        end else begin
          rd = READ_W'(head_val);
        end
      end
      ACT_REVERSE: begin
        rev_next = !rev;
      end
      ACT_CLEAR: begin
        count_next = '0;
        rev_next   = 1'b0;
      end
      default: begin
        status = ST_OK;
      end
    endcase

    cmd.rev   = rev;
    cmd.op    = CELL_HOLD;
    sel_index = IW'(exec_q);
    if (state == S_SCAN) begin
      cmd.op    = (act == ACT_READ) ? CELL_SCAN_POS : CELL_SCAN_VAL;
      sel_index = IW'(scan_q);
    end else if ((state == S_EXEC) && out_free) begin
      cmd.op = exec_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      rev      <= 1'b0;
      scan_cnt <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !((state == S_EXEC) && out_free)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          scan_cnt <= '0;
          if (s_tvalid) begin
            state <= needs_scan ? S_SCAN : S_EXEC;
          end
        end
        S_SCAN: begin
          scan_cnt <= scan_cnt + IW'(1);
          if (scan_cnt == SCAN_LAST) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            count    <= count_next;
            rev      <= rev_next;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      act <= s_tdata[3:0];
      pos <= s_tdata[10:4];
      key <= DATA_WIDTH'(s_tdata[42:11]);
    end
    if ((state == S_EXEC) && out_free) begin
      m_tdata <= {(count_next == '0), COUNT_W'(count_next), fidx, rd, status};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_count_commit: assert property (@(posedge clk) disable iff (rst)
    !((state == S_EXEC) && out_free) |=> $stable(count))
    else $error("entry count moved outside a commit");

  a_read_hit: assert property (@(posedge clk) disable iff (rst)
    ((state == S_EXEC) && (act == ACT_READ) && (p < cnt)) |-> head_hit)
    else $error("valid read reached commit without a chain hit");

endmodule

`default_nettype wire

[dv/list_checker.sv]
`timescale 1ns / 1ps

// Watches both stream channels, keeps its own copy of the list and checks every
// result word against the oldest prediction still waiting.
module list_checker #(
  parameter int CAPACITY = oale_pkg::CAPACITY_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  input  wire logic                           s_tready,
  input  wire logic [oale_pkg::S_TDATA_W-1:0] s_tdata,
  input  wire logic                           m_tvalid,
  input  wire logic                           m_tready,
  input  wire logic [oale_pkg::M_TDATA_W-1:0] m_tdata,
  output int                                  fail_count,
  output int                                  pending,
  output logic [6:0]                          list_len
);
  import oale_pkg::*;

  typedef struct packed {
    status_t     status;
    logic [31:0] read_value;
    logic [5:0]  found_index;
    logic [6:0]  entry_count;
    logic        is_empty;
  } list_result_t;

  logic [31:0]  store [CAPACITY];
  int           len;
  list_result_t result_q [$];
  list_result_t got;
  list_result_t want;

  initial begin
    fail_count = 0;
    pending    = 0;
    list_len   = '0;
    len        = 0;
    for (int i = 0; i < CAPACITY; i++) store[i] = '0;
  end

  // close the gap left at p; the freed top slot goes back to zero
  task automatic squeeze_out(input int p);
    for (int i = p; i + 1 < len; i++) store[i] = store[i + 1];
    store[len - 1] = '0;
    len--;
  endtask

  task automatic apply_op(input logic [3:0] act, input logic [6:0] pos,
                          input logic [31:0] val, output list_result_t r);
    int          hit;
    logic [31:0] tmp;
    r   = '0;
    hit = -1;
    if (act == ACT_REMOVE_VAL || act == ACT_FIND)
      for (int i = 0; i < len; i++)
        if (hit < 0 && store[i] == val) hit = i;
    case (act)
      ACT_APPEND: begin
        if (len >= CAPACITY) r.status = ST_FULL;
        else begin
          store[len] = val;
          len++;
        end
      end
      ACT_REMOVE_END: begin
        if (len == 0) r.status = ST_BADPOS;
        else begin
          store[len - 1] = '0;
          len--;
        end
      end
      ACT_INSERT: begin
        // position is checked ahead of the full flag
        if (int'(pos) > len) r.status = ST_BADPOS;
        else if (len >= CAPACITY) r.status = ST_FULL;
        else begin
          for (int i = len; i > int'(pos); i--) store[i] = store[i - 1];
          store[pos] = val;
          len++;
        end
      end
      ACT_ERASE: begin
        if (int'(pos) >= len) r.status = ST_BADPOS;
        else squeeze_out(int'(pos));
      end
      ACT_REMOVE_VAL: begin
        if (hit < 0) r.status = ST_NOTFOUND;
        else begin
          r.found_index = hit[5:0];
          squeeze_out(hit);
        end
      end
      ACT_FIND: begin
        if (hit < 0) r.status = ST_NOTFOUND;
        else r.found_index = hit[5:0];
      end
      ACT_READ: begin
        if (int'(pos) >= len) r.status = ST_BADPOS;
        else r.read_value = store[pos];
      end
      ACT_REVERSE: begin
        for (int i = 0; i < len / 2; i++) begin
          tmp                = store[i];
          store[i]           = store[len - 1 - i];
          store[len - 1 - i] = tmp;
        end
      end
      ACT_CLEAR: begin
        for (int i = 0; i < CAPACITY; i++) store[i] = '0;
        len = 0;
      end
      default: ; // spare codes leave the list alone
    endcase
    r.entry_count = len[6:0];
    r.is_empty    = (len == 0);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      len = 0;
      result_q.delete();
    end else begin
      // results first: a word arriving this edge cannot be answered yet
      if (m_tvalid && m_tready) begin
        got.status      = status_t'(m_tdata[1:0]);
        got.read_value  = m_tdata[33:2];
        got.found_index = m_tdata[39:34];
        got.entry_count = m_tdata[46:40];
        got.is_empty    = m_tdata[47];
        if (result_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result word %h", m_tdata);
        end else begin
          want = result_q.pop_front();
          if (got.status !== want.status || got.read_value !== want.read_value ||
              got.found_index !== want.found_index ||
              got.entry_count !== want.entry_count || got.is_empty !== want.is_empty) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result mismatch: exp st=%0d rd=%h idx=%0d cnt=%0d empty=%0b",
                       want.status, want.read_value, want.found_index,
                       want.entry_count, want.is_empty,
                       " / got st=%0d rd=%h idx=%0d cnt=%0d empty=%0b",
                       got.status, got.read_value, got.found_index,
                       got.entry_count, got.is_empty);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        apply_op(s_tdata[3:0], s_tdata[10:4], s_tdata[42:11], want);
        result_q = {result_q, want};
      end
    end
    pending  = result_q.size();
    list_len = len[6:0];
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import oale_pkg::*;

  localparam int CAPACITY       = CAPACITY_DEF;
  localparam int SCAN_CYCLES    = CAPACITY + 2;
  localparam int STALL_LIMIT    = 4000;
  localparam int WORDS_PER_PASS = 100;
  localparam int SPARE_FIRST    = 9;
  localparam int SPARE_LAST     = 15;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;

  int         fail_count;
  int         pending;
  logic [6:0] list_len;
  int         src_idle_pct = 0;
  int         sink_stall_pct = 0;
  int         quiet_cycles = 0;

  always #10 clk = ~clk;

  ordered_array_list_engine dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  list_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .pending    (pending),
    .list_len   (list_len)
  );

  always @(negedge clk)
    m_tready = !(sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct);

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_word(input logic [3:0] act, input logic [6:0] pos,
                           input logic [31:0] val);
    while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {5'b0, val, pos, act};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  initial begin
    logic [3:0]  act;
    logic [6:0]  pos;
    logic [31:0] val;
    int          pick;
    bit          filling;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty list corners, then small list edits, bad positions, spare codes and clear
    send_word(ACT_REMOVE_END, 7'd0, 32'd0);
    send_word(ACT_ERASE, 7'd0, 32'd0);
    send_word(ACT_READ, 7'd0, 32'd0);
    send_word(ACT_FIND, 7'd0, 32'd0);
    send_word(ACT_REMOVE_VAL, 7'd0, 32'd0);
    send_word(ACT_REVERSE, 7'd0, 32'd0);
    send_word(ACT_INSERT, 7'd1, 32'h1111_1111);
    send_word(ACT_INSERT, 7'd0, 32'hFFFF_FFFF);
    send_word(ACT_REVERSE, 7'd0, 32'd0);
    send_word(ACT_APPEND, 7'd0, 32'd0);
    send_word(ACT_APPEND, 7'd0, 32'h5A5A_5A5A);
    send_word(ACT_INSERT, 7'd3, 32'h1234_5678);
    send_word(ACT_INSERT, 7'd1, 32'h8000_0001);
    send_word(ACT_READ, 7'd4, 32'd0);
    send_word(ACT_READ, 7'd127, 32'd0);
    send_word(ACT_FIND, 7'd0, 32'h5A5A_5A5A);
    send_word(ACT_REVERSE, 7'd0, 32'd0);
    send_word(ACT_READ, 7'd0, 32'd0);
    send_word(ACT_ERASE, 7'd1, 32'd0);
    send_word(ACT_REMOVE_VAL, 7'd0, 32'd0);
    send_word(ACT_REMOVE_END, 7'd0, 32'd0);
    send_word(4'(SPARE_LAST), 7'd127, 32'hFFFF_FFFF);
    send_word(4'(SPARE_FIRST), 7'd0, 32'd0);
    send_word(ACT_CLEAR, 7'd0, 32'd0);
    send_word(ACT_INSERT, 7'd0, 32'd7);

    filling = 1'b1;
    for (int pass = 0; pass < 4; pass++) begin
      case (pass)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 80; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 80; end
        default: begin src_idle_pct = 8; sink_stall_pct = 8; end
      endcase
      repeat (WORDS_PER_PASS) begin
        // filling runs push the list up to capacity and keep hitting the full flag
        pick = $urandom_range(0, 99);
        if (filling && pick < 80) act = (pick < 50) ? ACT_APPEND : ACT_INSERT;
        else begin
          pick = $urandom_range(0, 99);
          if (pick < 12) act = ACT_APPEND;
          else if (pick < 22) act = ACT_REMOVE_END;
          else if (pick < 34) act = ACT_INSERT;
          else if (pick < 46) act = ACT_ERASE;
          else if (pick < 58) act = ACT_REMOVE_VAL;
          else if (pick < 70) act = ACT_FIND;
          else if (pick < 86) act = ACT_READ;
          else if (pick < 92) act = ACT_REVERSE;
          else if (pick < 94) act = ACT_CLEAR;
          else act = 4'($urandom_range(SPARE_FIRST, SPARE_LAST));
        end
        if (filling && list_len == CAPACITY && $urandom_range(0, 5) == 0) filling = 1'b0;
        else if (!filling && $urandom_range(0, 39) == 0) filling = 1'b1;

        // a small value pool so that find and remove value often hit
        case ($urandom_range(0, 7))
          0, 1, 2, 3: val = $urandom_range(0, 11);
          4, 5:       val = $urandom;
          6:          val = 32'hFFFF_FFFF;
          default:    val = 32'h8000_0000 | $urandom_range(0, 3);
        endcase

        pick = $urandom_range(0, 9);
        if (pick < 6) pos = 7'($urandom_range(0, list_len));
        else if (pick < 8) pos = (list_len == 0) ? 7'd0 : list_len - 7'd1;
        else pos = 7'($urandom);

        send_word(act, pos, val);
      end
      // hold off until the block has answered everything
      s_tvalid = 1'b0;
      while (pending != 0) @(negedge clk);
    end

    repeat (2 * SCAN_CYCLES + 8) @(posedge clk);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
